### sv/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
// No dependencies; every other file refers to it by scoped names.
package rau_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_LT  = 3'd4;
  localparam logic [2:0] OP_EQ  = 3'd5;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic               compare_flag;
    logic               status;
  } out_t;

  // classified word passed from front to back
  typedef struct packed {
    logic [2:0]  op;
    logic        bad;     // a zero denominator
    logic        a_neg;
    logic        b_neg;
    logic [31:0] an;
    logic [31:0] ad;
    logic [31:0] bn;
    logic [31:0] bd;
  } job_t;

endpackage

### sv/rau_front.sv
// Front end: splits the operand fields into sign and magnitude and flags
// zero denominators. Depends on rau_pkg.
module rau_front #(
  parameter int OPERAND_BITS = 32
) (
  input  rau_pkg::in_t  in_word,
  output rau_pkg::job_t job
);

  logic [OPERAND_BITS-1:0] an_v, ad_v, bn_v, bd_v;
  logic [OPERAND_BITS-1:0] an_m, ad_m, bn_m, bd_m;

  assign an_v = in_word.a_num[OPERAND_BITS-1:0];
  assign ad_v = in_word.a_den[OPERAND_BITS-1:0];
  assign bn_v = in_word.b_num[OPERAND_BITS-1:0];
  assign bd_v = in_word.b_den[OPERAND_BITS-1:0];

  // most negative value negates onto itself, read as unsigned it is right
  assign an_m = an_v[OPERAND_BITS-1] ? (~an_v + 1'b1) : an_v;
  assign ad_m = ad_v[OPERAND_BITS-1] ? (~ad_v + 1'b1) : ad_v;
  assign bn_m = bn_v[OPERAND_BITS-1] ? (~bn_v + 1'b1) : bn_v;
  assign bd_m = bd_v[OPERAND_BITS-1] ? (~bd_v + 1'b1) : bd_v;

  always_comb begin
    job.op    = in_word.operation;
    job.bad   = (ad_v == '0) || (bd_v == '0);
    job.a_neg = an_v[OPERAND_BITS-1] ^ ad_v[OPERAND_BITS-1];
    job.b_neg = bn_v[OPERAND_BITS-1] ^ bd_v[OPERAND_BITS-1];
    job.an    = 32'(an_m);
    job.ad    = 32'(ad_m);
    job.bn    = 32'(bn_m);
    job.bd    = 32'(bd_m);
  end

endmodule

### sv/rau_fifo.sv
// Short queue of classified words between front and back.
// Depends on rau_pkg.
module rau_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rau_pkg::job_t push_word,
  input  logic          pop,
  output rau_pkg::job_t head,
  output logic          full,
  output logic          empty
);

  localparam int AW = $clog2(rau_pkg::QUEUE_DEPTH);

  rau_pkg::job_t        slot_r [rau_pkg::QUEUE_DEPTH];
  logic [AW-1:0]        wr_r, rd_r;
  logic [AW:0]          cnt_r;

  assign full  = (cnt_r == (AW+1)'(rau_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == AW'(rau_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == AW'(rau_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

### sv/rau_back.sv
// Back end: sequencer over a binary GCD stepper, a restoring divider and
// one 32x32 multiplier. Depends on rau_pkg.
module rau_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          empty,
  input  rau_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  output rau_pkg::out_t out_word
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GLD  = 4'd1;
  localparam logic [3:0] S_GCD  = 4'd2;
  localparam logic [3:0] S_DVN  = 4'd3;
  localparam logic [3:0] S_DVD  = 4'd4;
  localparam logic [3:0] S_A    = 4'd5;
  localparam logic [3:0] S_B    = 4'd6;
  localparam logic [3:0] S_OP   = 4'd7;
  localparam logic [3:0] S_MUL2 = 4'd8;
  localparam logic [3:0] S_M1   = 4'd9;
  localparam logic [3:0] S_M2   = 4'd10;
  localparam logic [3:0] S_M3   = 4'd11;
  localparam logic [3:0] S_ADD  = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0]  st_r, st_nxt, ret_r, ret_nxt;
  logic [2:0]  op_r, op_nxt;
  logic        aneg_r, aneg_nxt, bneg_r, bneg_nxt, rneg_r, rneg_nxt;
  logic [63:0] num_r, num_nxt, den_r, den_nxt;
  logic [31:0] ra_n_r, ra_n_nxt, ra_d_r, ra_d_nxt, rb_n_r, rb_n_nxt, rb_d_r, rb_d_nxt;
  logic [63:0] x_r, x_nxt, y_r, y_nxt, g_r, g_nxt;
  logic [6:0]  k_r, k_nxt;
  logic [63:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] t1_r, t1_nxt, t2_r, t2_nxt, l_r, l_nxt;
  logic        ov_r, ov_nxt;
  rau_pkg::out_t out_r, out_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [64:0] r2;
  logic        dv_bit;
  logic [63:0] dv_rem, dv_quo;
  logic signed [64:0] sa, sb;

  assign out_valid = ov_r;
  assign out_word  = out_r;

  always_comb begin
    case (st_r)
      S_OP:    begin
        mul_a = ra_n_r;
        mul_b = (op_r == rau_pkg::OP_DIV) ? rb_d_r : rb_n_r;
      end
      S_MUL2:  begin
        mul_a = ra_d_r;
        mul_b = (op_r == rau_pkg::OP_DIV) ? rb_n_r : rb_d_r;
      end
      S_M1:    begin mul_a = ra_n_r; mul_b = num_r[31:0]; end
      S_M2:    begin mul_a = ra_d_r; mul_b = num_r[31:0]; end
      S_M3:    begin mul_a = rb_n_r; mul_b = den_r[31:0]; end
      default: begin mul_a = '0;     mul_b = '0;          end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
  end

  // one restoring division step
  always_comb begin
    r2     = {rem_r, quo_r[63]};
    dv_bit = (r2 >= {1'b0, g_r});
    dv_rem = dv_bit ? 64'(r2 - {1'b0, g_r}) : r2[63:0];
    dv_quo = {quo_r[62:0], dv_bit};
    sa     = aneg_r ? -$signed({1'b0, t1_r}) : $signed({1'b0, t1_r});
    sb     = bneg_r ? -$signed({1'b0, t2_r}) : $signed({1'b0, t2_r});
  end

  always_comb begin
    st_nxt = st_r;  ret_nxt = ret_r;  op_nxt = op_r;
    aneg_nxt = aneg_r;  bneg_nxt = bneg_r;  rneg_nxt = rneg_r;
    num_nxt = num_r;  den_nxt = den_r;
    ra_n_nxt = ra_n_r;  ra_d_nxt = ra_d_r;  rb_n_nxt = rb_n_r;  rb_d_nxt = rb_d_r;
    x_nxt = x_r;  y_nxt = y_r;  g_nxt = g_r;  k_nxt = k_r;
    rem_nxt = rem_r;  quo_nxt = quo_r;  cnt_nxt = cnt_r;
    t1_nxt = t1_r;  t2_nxt = t2_r;  l_nxt = l_r;
    ov_nxt = 1'b0;
    out_nxt = out_r;
    pop = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (!empty) begin
          pop      = 1'b1;
          op_nxt   = head.op;
          aneg_nxt = head.a_neg;
          bneg_nxt = head.b_neg;
          num_nxt  = 64'(head.an);
          den_nxt  = 64'(head.ad);
          rb_n_nxt = head.bn;
          rb_d_nxt = head.bd;
          if (head.bad) begin
            ov_nxt  = 1'b1;
            out_nxt = '{res_num: '0, res_den: 63'd1, compare_flag: 1'b0, status: 1'b1};
          end else begin
            ret_nxt = S_A;
            st_nxt  = S_GLD;
          end
        end
      end
      S_GLD: begin
        x_nxt  = num_r;
        y_nxt  = den_r;
        k_nxt  = '0;
        st_nxt = S_GCD;
      end
      S_GCD: begin
        if (x_r == '0 || y_r == '0) begin
          g_nxt   = (x_r | y_r) << k_r;
          if (g_nxt == '0) g_nxt = 64'd1;
          rem_nxt = '0;
          quo_nxt = num_r;
          cnt_nxt = '0;
          st_nxt  = S_DVN;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r >= y_r) begin
          x_nxt = x_r - y_r;
        end else begin
          y_nxt = y_r - x_r;
        end
      end
      S_DVN: begin
        rem_nxt = dv_rem;
        quo_nxt = dv_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'd63) begin
          num_nxt = dv_quo;
          rem_nxt = '0;
          quo_nxt = den_r;
          st_nxt  = S_DVD;
        end
      end
      S_DVD: begin
        rem_nxt = dv_rem;
        quo_nxt = dv_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'd63) begin
          den_nxt = dv_quo;
          st_nxt  = ret_r;
        end
      end
      S_A: begin
        ra_n_nxt = num_r[31:0];
        ra_d_nxt = (num_r == '0) ? 32'd1 : den_r[31:0];
        aneg_nxt = aneg_r && (num_r != '0);
        num_nxt  = 64'(rb_n_r);
        den_nxt  = 64'(rb_d_r);
        ret_nxt  = S_B;
        st_nxt   = S_GLD;
      end
      S_B: begin
        rb_n_nxt = num_r[31:0];
        rb_d_nxt = (num_r == '0) ? 32'd1 : den_r[31:0];
        bneg_nxt = bneg_r && (num_r != '0);
        if (op_r == rau_pkg::OP_SUB) begin
          bneg_nxt = !bneg_r && (num_r != '0);
        end
        st_nxt = S_OP;
      end
      S_OP: begin
        case (op_r)
          rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_LT: begin
            // gcd of the denominators, then both divided: q1 in num, q2 in den
            num_nxt = 64'(rb_d_r);
            den_nxt = 64'(ra_d_r);
            ret_nxt = S_M1;
            st_nxt  = S_GLD;
          end
          rau_pkg::OP_MUL: begin
            num_nxt  = prod;
            rneg_nxt = aneg_r ^ bneg_r;
            st_nxt   = S_MUL2;
          end
          rau_pkg::OP_DIV: begin
            if (rb_n_r == '0) begin
              ov_nxt  = 1'b1;
              out_nxt = '{res_num: '0, res_den: 63'd1, compare_flag: 1'b0, status: 1'b1};
              st_nxt  = S_IDLE;
            end else begin
              num_nxt  = prod;
              rneg_nxt = aneg_r ^ bneg_r;
              st_nxt   = S_MUL2;
            end
          end
          rau_pkg::OP_EQ: begin
            ov_nxt  = 1'b1;
            out_nxt = '{res_num: '0, res_den: 63'd1,
                        compare_flag: (aneg_r == bneg_r) && (ra_n_r == rb_n_r)
                                      && (ra_d_r == rb_d_r),
                        status: 1'b0};
            st_nxt  = S_IDLE;
          end
          default: begin
            ov_nxt  = 1'b1;
            out_nxt = '{res_num: '0, res_den: 63'd1, compare_flag: 1'b0, status: 1'b0};
            st_nxt  = S_IDLE;
          end
        endcase
      end
      S_MUL2: begin
        den_nxt = prod;
        ret_nxt = S_FIN;
        st_nxt  = S_GLD;
      end
      S_M1: begin t1_nxt = prod; st_nxt = S_M2; end
      S_M2: begin l_nxt  = prod; st_nxt = S_M3; end
      S_M3: begin t2_nxt = prod; st_nxt = S_ADD; end
      S_ADD: begin
        if (op_r == rau_pkg::OP_LT) begin
          ov_nxt  = 1'b1;
          out_nxt = '{res_num: '0, res_den: 63'd1, compare_flag: (sa < sb), status: 1'b0};
          st_nxt  = S_IDLE;
        end else begin
          if (aneg_r == bneg_r) begin
            num_nxt  = t1_r + t2_r;
            rneg_nxt = aneg_r;
          end else if (t1_r >= t2_r) begin
            num_nxt  = t1_r - t2_r;
            rneg_nxt = aneg_r;
          end else begin
            num_nxt  = t2_r - t1_r;
            rneg_nxt = bneg_r;
          end
          den_nxt = l_r;
          ret_nxt = S_FIN;
          st_nxt  = S_GLD;
        end
      end
      S_FIN: begin
        ov_nxt = 1'b1;
        out_nxt.compare_flag = 1'b0;
        out_nxt.status       = 1'b0;
        if (num_r == '0) begin
          out_nxt.res_num = '0;
          out_nxt.res_den = 63'd1;
        end else begin
          out_nxt.res_den = den_r[62:0];
          if (rneg_r) out_nxt.res_num = -$signed(num_r);
          else        out_nxt.res_num = num_r[63] ? 64'h7fff_ffff_ffff_ffff : num_r;
        end
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;  op_r <= op_nxt;
    aneg_r <= aneg_nxt;  bneg_r <= bneg_nxt;  rneg_r <= rneg_nxt;
    num_r <= num_nxt;  den_r <= den_nxt;
    ra_n_r <= ra_n_nxt;  ra_d_r <= ra_d_nxt;  rb_n_r <= rb_n_nxt;  rb_d_r <= rb_d_nxt;
    x_r <= x_nxt;  y_r <= y_nxt;  g_r <= g_nxt;  k_r <= k_nxt;
    rem_r <= rem_nxt;  quo_r <= quo_nxt;  cnt_r <= cnt_nxt;
    t1_r <= t1_nxt;  t2_r <= t2_nxt;  l_r <= l_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule

### sv/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: front end, word queue, back end.
// Depends on rau_pkg, rau_front, rau_fifo and rau_back.
//
// Usage: drive in_word and raise start; the word is taken at an edge where
// start is high and busy is low. busy rises only when the two-entry queue
// is full. Each word gives exactly one result, shown on out_word for a
// single cycle with out_valid high; the receiver must take it then.
// A zero denominator is answered straight from the back end's idle state,
// with no reduction. Every other word is reduced operand by operand; one
// reduction is a load step, one binary GCD step per cycle, a finishing
// step and two 64-bit restoring divisions. Equal, unused codes and
// division by zero run two reductions, less-than, multiply and divide
// three, add and subtract four. The back end works on one word at a time
// and takes the next word from the queue only in its idle state.
// Reset (rst_n low, synchronous) empties the queue and idles the back end.
module rational_arithmetic_unit #(
  parameter int OPERAND_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rau_pkg::in_t  in_word,
  output logic          out_valid,
  output rau_pkg::out_t out_word
);

  rau_pkg::job_t job, head;
  logic          full, empty, pop, push;

  assign busy = full;
  assign push = start && !full;

  rau_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
    .in_word (in_word),
    .job     (job)
  );

  rau_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (job),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  rau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
